[rtl/b64kx_pkg.sv]
// b64kx_pkg: shared constants, register map and helper functions for the
// base64 decoder with repeating-key XOR. No dependencies.

package b64kx_pkg;

	localparam int unsigned MAX_KEY_BYTES_DEF = 16;
	localparam int unsigned KEY_POS_W         = 4;
	localparam int unsigned KEY_BITS          = 128;
	localparam int unsigned DATA_W            = 64;
	localparam int unsigned ADDR_W            = 5;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [63:0] KEY_LOW_RESET    = 64'd0;
	localparam logic [63:0] KEY_HIGH_RESET   = 64'd0;
	localparam logic [4:0]  KEY_LEN_RESET    = 5'd1;
	localparam logic [7:0]  MAX_GROUPS_RESET = 8'd42;

	typedef enum logic [1:0] {
		REG_KEY_LOW    = 2'd0,
		REG_KEY_HIGH   = 2'd1,
		REG_KEY_LENGTH = 2'd2,
		REG_MAX_GROUPS = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_LENGTH   = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2,
		POS_FOURTH = 2'd3
	} group_pos_t;

	function automatic logic [5:0] sextet(input logic [7:0] c);
		logic [5:0] v;
		v = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			v = 6'd62;
		end else if (c == 8'h2F) begin
			v = 6'd63;
		end
		return v;
	endfunction

	function automatic logic [KEY_POS_W-1:0] key_advance(input logic [KEY_POS_W-1:0] pos,
			input logic [KEY_POS_W:0] len);
		logic [KEY_POS_W:0] sum;
		sum = {1'b0, pos} + (KEY_POS_W+1)'(1);
		return (sum >= len) ? '0 : sum[KEY_POS_W-1:0];
	endfunction

endpackage

[rtl/base64_decode_key_xor.sv]
// base64_decode_key_xor: streaming base64 decoder, one character per transfer,
// decoded bytes XORed with a repeating key; APB-style register port.
// Depends on b64kx_pkg.
//
//  channel   | valid / ready              | payload
//  ----------+----------------------------+------------------------------------------
//  character | char_valid / char_ready    | character, last
//  result    | result_valid / result_ready| byte_0..2, byte_count, status, end_of_message
//  config    | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One character per cycle while the result channel is not stalled; a character passes
// through the input register, then decode and key XOR into the result register.
// arst_n clears the message state, the stage valids and loads register defaults.
// A stalled result holds the result register; the input register still drains
// characters that yield no result, and takes a new one when its own moves on.

module base64_decode_key_xor #(
	parameter int unsigned MAX_KEY_BYTES = b64kx_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              char_valid,
	output logic                              char_ready,
	input  logic [7:0]                        character,
	input  logic                              last,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [7:0]                        byte_0,
	output logic [7:0]                        byte_1,
	output logic [7:0]                        byte_2,
	output logic [1:0]                        byte_count,
	output logic [1:0]                        status,
	output logic                              end_of_message,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [b64kx_pkg::ADDR_W-1:0]      paddr,
	input  logic [b64kx_pkg::DATA_W-1:0]      pwdata,
	output logic [b64kx_pkg::DATA_W-1:0]      prdata,
	output logic                              pready
);

	localparam int unsigned PW = b64kx_pkg::KEY_POS_W;
	localparam logic [PW:0] MaxLen = (PW+1)'(MAX_KEY_BYTES);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  key_length_q;
	logic [7:0]  max_groups_q;

	logic [17:0]                  group_values_q;
	b64kx_pkg::group_pos_t        group_pos_q;
	logic                         third_pad_q;
	logic [PW-1:0]                key_pos_q;
	logic [7:0]                   group_count_q;
	logic                         overflow_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic                  valid_s2;
	logic [7:0]            b0_s2;
	logic [7:0]            b1_s2;
	logic [7:0]            b2_s2;
	logic [1:0]            count_s2;
	b64kx_pkg::status_t    status_s2;
	logic                  eom_s2;

	logic                   wr_en;
	b64kx_pkg::reg_index_t  wr_idx;

	logic [5:0]               v;
	logic                     is_pad;
	logic                     completes;
	logic                     has_result;
	logic                     out_free;
	logic                     fire;
	logic [PW:0]              len;
	logic [PW-1:0]            p1, p2, p3;
	logic [b64kx_pkg::KEY_BITS-1:0] key_all;
	logic [7:0]               k0, k1, k2;
	logic [7:0]               r0, r1, r2;
	logic [7:0]               nb0, nb1, nb2;
	logic [1:0]               ncount;
	logic [PW-1:0]            npos;
	b64kx_pkg::status_t       nstatus;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = b64kx_pkg::reg_index_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= b64kx_pkg::KEY_LOW_RESET;
			key_high_q   <= b64kx_pkg::KEY_HIGH_RESET;
			key_length_q <= b64kx_pkg::KEY_LEN_RESET;
			max_groups_q <= b64kx_pkg::MAX_GROUPS_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				b64kx_pkg::REG_KEY_LOW:    key_low_q    <= pwdata;
				b64kx_pkg::REG_KEY_HIGH:   key_high_q   <= pwdata;
				b64kx_pkg::REG_KEY_LENGTH: key_length_q <= pwdata[4:0];
				b64kx_pkg::REG_MAX_GROUPS: max_groups_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (b64kx_pkg::reg_index_t'(paddr[4:3]))
			b64kx_pkg::REG_KEY_LOW:    prdata = key_low_q;
			b64kx_pkg::REG_KEY_HIGH:   prdata = key_high_q;
			b64kx_pkg::REG_KEY_LENGTH: prdata = {59'd0, key_length_q};
			b64kx_pkg::REG_MAX_GROUPS: prdata = {56'd0, max_groups_q};
			default:                   prdata = '0;
		endcase
	end

	// decode of the character held in the input register
	assign v          = b64kx_pkg::sextet(char_s1);
	assign is_pad     = (char_s1 == b64kx_pkg::PAD_CHAR);
	assign completes  = (group_pos_q == b64kx_pkg::POS_FOURTH);
	assign has_result = completes || last_s1;
	assign out_free   = !valid_s2 || result_ready;
	assign fire       = valid_s1 && (!has_result || out_free);
	assign char_ready = !valid_s1 || fire;

	always_comb begin
		if (key_length_q == 5'd0) begin
			len = (PW+1)'(1);
		end else if ((PW+1)'(key_length_q) > MaxLen) begin
			len = MaxLen;
		end else begin
			len = (PW+1)'(key_length_q);
		end
	end

	assign key_all = {key_high_q, key_low_q};
	assign p1 = b64kx_pkg::key_advance(key_pos_q, len);
	assign p2 = b64kx_pkg::key_advance(p1, len);
	assign p3 = b64kx_pkg::key_advance(p2, len);
	assign k0 = key_all[{key_pos_q, 3'b000} +: 8];
	assign k1 = key_all[{p1, 3'b000} +: 8];
	assign k2 = key_all[{p2, 3'b000} +: 8];
	assign r0 = {group_values_q[17:12], group_values_q[11:10]};
	assign r1 = {group_values_q[9:6], group_values_q[5:2]};
	assign r2 = {group_values_q[1:0], v};

	always_comb begin
		nb0     = 8'd0;
		nb1     = 8'd0;
		nb2     = 8'd0;
		ncount  = 2'd0;
		npos    = key_pos_q;
		nstatus = b64kx_pkg::STATUS_OK;
		if (completes) begin
			nb0 = r0 ^ k0;
			if (!third_pad_q) begin
				nb1 = r1 ^ k1;
				if (!is_pad) begin
					nb2    = r2 ^ k2;
					ncount = 2'd3;
					npos   = p3;
				end else begin
					ncount = 2'd2;
					npos   = p2;
				end
			end else if (!is_pad) begin
				nb1    = r2 ^ k1;
				ncount = 2'd2;
				npos   = p2;
			end else begin
				ncount = 2'd1;
				npos   = p1;
			end
			if (last_s1 && overflow_q) begin
				nstatus = b64kx_pkg::STATUS_OVERFLOW;
			end
		end else if (last_s1) begin
			nstatus = b64kx_pkg::STATUS_LENGTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= character;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_values_q <= '0;
			group_pos_q    <= b64kx_pkg::POS_FIRST;
			third_pad_q    <= 1'b0;
			key_pos_q      <= '0;
			group_count_q  <= '0;
			overflow_q     <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				group_values_q <= '0;
				group_pos_q    <= b64kx_pkg::POS_FIRST;
				third_pad_q    <= 1'b0;
				key_pos_q      <= '0;
				group_count_q  <= '0;
				overflow_q     <= 1'b0;
			end else if (completes) begin
				group_values_q <= '0;
				group_pos_q    <= b64kx_pkg::POS_FIRST;
				third_pad_q    <= 1'b0;
				key_pos_q      <= npos;
			end else begin
				group_values_q <= {group_values_q[11:0], v};
				group_pos_q    <= b64kx_pkg::group_pos_t'(group_pos_q + 2'd1);
				if (group_pos_q == b64kx_pkg::POS_THIRD) begin
					third_pad_q <= is_pad;
				end
				if (group_pos_q == b64kx_pkg::POS_FIRST) begin
					if (group_count_q >= max_groups_q) begin
						overflow_q <= 1'b1;
					end
					if (group_count_q != 8'hFF) begin
						group_count_q <= group_count_q + 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && has_result) begin
			b0_s2     <= nb0;
			b1_s2     <= nb1;
			b2_s2     <= nb2;
			count_s2  <= ncount;
			status_s2 <= nstatus;
			eom_s2    <= last_s1;
		end
	end

	assign result_valid   = valid_s2;
	assign byte_0         = b0_s2;
	assign byte_1         = b1_s2;
	assign byte_2         = b2_s2;
	assign byte_count     = count_s2;
	assign status         = status_s2;
	assign end_of_message = eom_s2;

endmodule

[rtl/b64kx_checker.sv]
// b64kx_checker: port-level assertions for base64_decode_key_xor, and the
// bind that attaches them. Depends on b64kx_pkg.

module b64kx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] byte_0,
	input logic [7:0] byte_1,
	input logic [7:0] byte_2,
	input logic [1:0] byte_count,
	input logic [1:0] status,
	input logic       end_of_message
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(byte_0) &&
		$stable(byte_1) && $stable(byte_2) && $stable(byte_count) &&
		$stable(status) && $stable(end_of_message))
		else $error("result changed while stalled");

	a_unused_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (byte_count == 2'd3 || byte_2 == 8'd0) &&
		(byte_count == 2'd3 || byte_count == 2'd2 || byte_1 == 8'd0) &&
		(byte_count != 2'd0 || byte_0 == 8'd0))
		else $error("byte beyond count is not zero");

	a_mid_message: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !end_of_message |->
		status == b64kx_pkg::STATUS_OK && byte_count != 2'd0)
		else $error("mid-message result without bytes or with status");

	a_length_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && byte_count == 2'd0 |->
		end_of_message && status == b64kx_pkg::STATUS_LENGTH)
		else $error("empty result that is not a length error");

	a_length_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == b64kx_pkg::STATUS_LENGTH |-> byte_count == 2'd0)
		else $error("length error carries bytes");

endmodule

bind base64_decode_key_xor b64kx_checker u_b64kx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.byte_0         (byte_0),
	.byte_1         (byte_1),
	.byte_2         (byte_2),
	.byte_count     (byte_count),
	.status         (status),
	.end_of_message (end_of_message)
);

[bench/tb_base64_decode_key_xor.sv]
`timescale 1ns / 100ps
// Testbench for base64_decode_key_xor: drives characters and APB register writes,
// predicts every decoded result in-bench and checks each result transfer field by field.
// Depends on b64kx_pkg and the base64_decode_key_xor RTL.

module tb_base64_decode_key_xor;

	localparam int unsigned RANDOM_ITEMS   = 850;
	localparam int unsigned DRAIN_LIMIT    = 1500;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [4:0]  KEY_SPAN_MAX   = 5'(b64kx_pkg::MAX_KEY_BYTES_DEF);

	typedef struct packed {
		logic [7:0]         b0;
		logic [7:0]         b1;
		logic [7:0]         b2;
		logic [1:0]         cnt;
		b64kx_pkg::status_t st;
		logic               eom;
	} decoded_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eom;
	} text_item_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           char_valid = 1'b0;
	logic                           char_ready;
	logic [7:0]                     character = 8'h00;
	logic                           last = 1'b0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	logic [7:0]                     byte_0;
	logic [7:0]                     byte_1;
	logic [7:0]                     byte_2;
	logic [1:0]                     byte_count;
	logic [1:0]                     status;
	logic                           end_of_message;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [b64kx_pkg::ADDR_W-1:0]   paddr = '0;
	logic [b64kx_pkg::DATA_W-1:0]   pwdata = '0;
	logic [b64kx_pkg::DATA_W-1:0]   prdata;
	logic                           pready;

	string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// register copies
	logic [63:0] key_lo = b64kx_pkg::KEY_LOW_RESET;
	logic [63:0] key_hi = b64kx_pkg::KEY_HIGH_RESET;
	logic [4:0]  key_len = b64kx_pkg::KEY_LEN_RESET;
	logic [7:0]  grp_limit = b64kx_pkg::MAX_GROUPS_RESET;

	// message state
	logic [17:0]           grp_bits = '0;
	b64kx_pkg::group_pos_t grp_pos = b64kx_pkg::POS_FIRST;
	logic                  third_pad = 1'b0;
	logic [3:0]            key_pos = '0;
	logic [7:0]            grp_cnt = '0;
	logic                  ovf = 1'b0;

	decoded_t    decoded_results[$];
	text_item_t  text_backlog[$];
	bit          no_idle = 1'b0;

	int unsigned n_errors = 0;
	int unsigned n_chars = 0;
	int unsigned n_results = 0;
	int unsigned n_msgs = 0;
	int unsigned n_len_err = 0;
	int unsigned n_ovf = 0;
	int unsigned n_phases = 0;
	int unsigned quiet_cycles = 0;

	base64_decode_key_xor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_ready     (char_ready),
		.character      (character),
		.last           (last),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.byte_0         (byte_0),
		.byte_1         (byte_1),
		.byte_2         (byte_2),
		.byte_count     (byte_count),
		.status         (status),
		.end_of_message (end_of_message),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [5:0] char_value(input logic [7:0] c);
		for (int i = 0; i < 64; i++) begin
			if (b64_alphabet[i] == c) begin
				return 6'(i);
			end
		end
		return 6'd0;
	endfunction

	function automatic logic [7:0] keyed(input logic [7:0] b);
		logic [4:0] span;
		logic [4:0] nxt;
		logic [7:0] kb;
		span = (key_len == 5'd0) ? 5'd1 : (key_len > KEY_SPAN_MAX) ? KEY_SPAN_MAX : key_len;
		kb = key_pos[3] ? key_hi[8*key_pos[2:0] +: 8] : key_lo[8*key_pos[2:0] +: 8];
		nxt = {1'b0, key_pos} + 5'd1;
		key_pos = (nxt >= span) ? 4'd0 : nxt[3:0];
		return b ^ kb;
	endfunction

	task automatic decode_char(input logic [7:0] c, input logic l);
		logic [5:0]         v;
		logic [7:0]         outb[3];
		int unsigned        n;
		logic               done;
		b64kx_pkg::status_t st;
		decoded_t           d;
		v = char_value(c);
		outb = '{default: 8'h00};
		n = 0;
		done = 1'b0;
		st = b64kx_pkg::STATUS_OK;
		if (grp_pos != b64kx_pkg::POS_FOURTH) begin
			if (grp_pos == b64kx_pkg::POS_FIRST) begin
				if (grp_cnt >= grp_limit) begin
					ovf = 1'b1;
				end
				if (grp_cnt != 8'hFF) begin
					grp_cnt = grp_cnt + 8'd1;
				end
			end
			grp_bits = {grp_bits[11:0], v};
			if (grp_pos == b64kx_pkg::POS_THIRD) begin
				third_pad = (c == b64kx_pkg::PAD_CHAR);
			end
			grp_pos = b64kx_pkg::group_pos_t'(grp_pos + 2'd1);
			if (l) begin
				st = b64kx_pkg::STATUS_LENGTH;
			end
		end else begin
			outb[n] = keyed({grp_bits[17:12], grp_bits[11:10]});
			n++;
			if (!third_pad) begin
				outb[n] = keyed({grp_bits[9:6], grp_bits[5:2]});
				n++;
			end
			if (c != b64kx_pkg::PAD_CHAR) begin
				outb[n] = keyed({grp_bits[1:0], v});
				n++;
			end
			grp_pos = b64kx_pkg::POS_FIRST;
			grp_bits = '0;
			third_pad = 1'b0;
			done = 1'b1;
			if (l && ovf) begin
				st = b64kx_pkg::STATUS_OVERFLOW;
			end
		end
		if (done || l) begin
			d.b0 = outb[0];
			d.b1 = outb[1];
			d.b2 = outb[2];
			d.cnt = 2'(n);
			d.st = l ? st : b64kx_pkg::STATUS_OK;
			d.eom = l;
			decoded_results.push_back(d);
		end
		if (l) begin
			grp_bits = '0;
			grp_pos = b64kx_pkg::POS_FIRST;
			third_pad = 1'b0;
			key_pos = '0;
			grp_cnt = '0;
			ovf = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	task automatic send_char(input logic [7:0] c, input logic l);
		int unsigned g;
		g = idle_len();
		if (g != 0) begin
			char_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		char_valid <= 1'b1;
		character <= c;
		last <= l;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		decode_char(c, l);
		n_chars++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	task automatic write_reg(input b64kx_pkg::reg_index_t idx, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			b64kx_pkg::REG_KEY_LOW:    key_lo = v;
			b64kx_pkg::REG_KEY_HIGH:   key_hi = v;
			b64kx_pkg::REG_KEY_LENGTH: key_len = v[4:0];
			b64kx_pkg::REG_MAX_GROUPS: grp_limit = v[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold the sender until every pending result is out or the drain limit is hit, then let the pipeline empty
	task automatic settle();
		int unsigned waited;
		decoded_t d;
		char_valid <= 1'b0;
		waited = 0;
		while (decoded_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		while (decoded_results.size() != 0) begin
			d = decoded_results.pop_front();
			report_mismatch("missing result", 32'd0, 32'(d));
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_message();
		int unsigned kind;
		int unsigned groups;
		int unsigned len;
		int unsigned pad;
		logic [7:0]  c;
		kind = $urandom_range(0, 99);
		pad = 0;
		if (kind < 70) begin
			if (grp_limit < 8'd6 && $urandom_range(0, 2) == 0) begin
				groups = grp_limit + $urandom_range(1, 2);
			end else begin
				groups = $urandom_range(1, 4);
			end
			len = 4 * groups;
			pad = $urandom_range(0, 3);
		end else if (kind < 90) begin
			len = $urandom_range(1, 13);
		end else begin
			len = $urandom_range(1, 8);
		end
		for (int i = 0; i < len; i++) begin
			if (kind >= 90 || $urandom_range(0, 11) == 0) begin
				c = 8'($urandom_range(0, 255));
			end else begin
				c = b64_alphabet[$urandom_range(0, 63)];
			end
			if (i == len - 1 && (pad == 1 || pad == 2)) begin
				c = b64kx_pkg::PAD_CHAR;
			end
			if (i == len - 2 && (pad == 2 || pad == 3)) begin
				c = b64kx_pkg::PAD_CHAR;
			end
			text_backlog.push_back('{c, i == len - 1});
		end
	endtask

	function automatic logic [63:0] pick_key_word();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	task automatic configure_phase(input int unsigned p);
		logic [4:0] klen;
		logic [7:0] mg;
		case (p)
			0:       klen = 5'd16;
			1:       klen = 5'd1;
			2:       klen = 5'd0;
			3:       klen = 5'd17;
			4:       klen = 5'd31;
			default: klen = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 16))
					: 5'($urandom_range(0, 31));
		endcase
		case (p)
			0:       mg = 8'd255;
			1:       mg = 8'd0;
			2:       mg = 8'd1;
			3:       mg = 8'd3;
			default: mg = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(1, 8))
					: 8'($urandom_range(0, 255));
		endcase
		if (p < 5 || $urandom_range(0, 1) == 1) begin
			write_reg(b64kx_pkg::REG_KEY_LOW, pick_key_word());
		end
		if (p < 5 || $urandom_range(0, 1) == 1) begin
			write_reg(b64kx_pkg::REG_KEY_HIGH, pick_key_word());
		end
		if (p < 5 || $urandom_range(0, 1) == 1) begin
			write_reg(b64kx_pkg::REG_KEY_LENGTH, 64'(klen));
		end
		if (p < 5 || $urandom_range(0, 1) == 1) begin
			write_reg(b64kx_pkg::REG_MAX_GROUPS, 64'(mg));
		end
	endtask

	task automatic test_padding();
		// unmapped bytes and '=' in the first two slots read as zero; '=' in the third or fourth slot shortens the group
		send_char(8'hFF, 1'b0);
		send_char("/", 1'b0);
		send_char(b64kx_pkg::PAD_CHAR, 1'b0);
		send_char("C", 1'b1);
		send_char(b64kx_pkg::PAD_CHAR, 1'b0);
		send_char(8'h00, 1'b0);
		send_char("+", 1'b0);
		send_char(b64kx_pkg::PAD_CHAR, 1'b1);
	endtask

	task automatic test_group_limit();
		settle();
		write_reg(b64kx_pkg::REG_MAX_GROUPS, 64'd1);
		send_text("QUJDQUJD");
		send_text("QUJDR");
		settle();
		write_reg(b64kx_pkg::REG_MAX_GROUPS, 64'd0);
		send_text("////");
	endtask

	task automatic test_random_traffic();
		int unsigned target;
		int unsigned phase;
		int unsigned burst;
		text_item_t  t;
		target = n_chars + RANDOM_ITEMS;
		phase = 0;
		while (n_chars < target) begin
			settle();
			configure_phase(phase);
			no_idle = ($urandom_range(0, 4) == 0);
			burst = $urandom_range(16, 96);
			repeat (burst) begin
				if (text_backlog.size() == 0) begin
					queue_message();
				end
				t = text_backlog.pop_front();
				send_char(t.ch, t.eom);
			end
			phase++;
			n_phases++;
		end
		no_idle = 1'b0;
		while (text_backlog.size() != 0) begin
			t = text_backlog.pop_front();
			send_char(t.ch, t.eom);
		end
	endtask

	initial begin
		int unsigned g;
		wait (arst_n);
		@(posedge clk);
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			g = idle_len();
			if (g != 0) begin
				result_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n && result_valid && result_ready) begin
			got = '{byte_0, byte_1, byte_2, byte_count,
					b64kx_pkg::status_t'(status), end_of_message};
			n_results++;
			if (got.eom) begin
				n_msgs++;
				if (got.st == b64kx_pkg::STATUS_LENGTH) begin
					n_len_err++;
				end
				if (got.st == b64kx_pkg::STATUS_OVERFLOW) begin
					n_ovf++;
				end
			end
			if (decoded_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(got), 32'd0);
			end else begin
				want = decoded_results.pop_front();
				if (got.b0 !== want.b0)
					report_mismatch("byte_0", 32'(got.b0), 32'(want.b0));
				if (got.b1 !== want.b1)
					report_mismatch("byte_1", 32'(got.b1), 32'(want.b1));
				if (got.b2 !== want.b2)
					report_mismatch("byte_2", 32'(got.b2), 32'(want.b2));
				if (got.cnt !== want.cnt)
					report_mismatch("byte_count", 32'(got.cnt), 32'(want.cnt));
				if (got.st !== want.st)
					report_mismatch("status", 32'(got.st), 32'(want.st));
				if (got.eom !== want.eom)
					report_mismatch("end_of_message", 32'(got.eom), 32'(want.eom));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (result_valid && result_ready)
				|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		@(posedge clk);
		test_padding();
		test_group_limit();
		test_random_traffic();
		settle();
		repeat (8) @(posedge clk);
		$display("decoded %0d characters over %0d register phases: %0d results, %0d messages",
				n_chars, n_phases, n_results, n_msgs);
		$display("messages with a length error: %0d, over the group limit: %0d",
				n_len_err, n_ovf);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
